### design/rgbled_pkg.sv
// Shared types, constants and the reciprocal table for the RGB to LED word pipeline.
package rgbled_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned LevelW  = 5;
	localparam int unsigned NumW    = 13;   // 31 * 255 + 15 fits in 13 bits
	localparam int unsigned RecipW  = 17;   // floor(2^16 / level), level 1 needs 17 bits
	localparam int unsigned RecipSh = 16;
	localparam int unsigned ProdW   = NumW + RecipW;
	localparam int unsigned RemW    = NumW + LevelW;

	localparam logic [LevelW-1:0] MaxLevel   = 5'd31;
	localparam logic [ChanW-1:0]  HeaderMark = 8'hE0;

	typedef logic [ChanW-1:0]  chan_t;
	typedef logic [LevelW-1:0] level_t;
	typedef logic [NumW-1:0]   num_t;
	typedef logic [RecipW-1:0] recip_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pix_t;

	// floor(65536 / level); level zero never occurs
	function automatic recip_t recip(input level_t lvl);
		recip_t r;
		case (lvl)
			5'd1:    r = 17'd65536;
			5'd2:    r = 17'd32768;
			5'd3:    r = 17'd21845;
			5'd4:    r = 17'd16384;
			5'd5:    r = 17'd13107;
			5'd6:    r = 17'd10922;
			5'd7:    r = 17'd9362;
			5'd8:    r = 17'd8192;
			5'd9:    r = 17'd7281;
			5'd10:   r = 17'd6553;
			5'd11:   r = 17'd5957;
			5'd12:   r = 17'd5461;
			5'd13:   r = 17'd5041;
			5'd14:   r = 17'd4681;
			5'd15:   r = 17'd4369;
			5'd16:   r = 17'd4096;
			5'd17:   r = 17'd3855;
			5'd18:   r = 17'd3640;
			5'd19:   r = 17'd3449;
			5'd20:   r = 17'd3276;
			5'd21:   r = 17'd3120;
			5'd22:   r = 17'd2978;
			5'd23:   r = 17'd2849;
			5'd24:   r = 17'd2730;
			5'd25:   r = 17'd2621;
			5'd26:   r = 17'd2520;
			5'd27:   r = 17'd2427;
			5'd28:   r = 17'd2340;
			5'd29:   r = 17'd2259;
			5'd30:   r = 17'd2184;
			5'd31:   r = 17'd2114;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### design/pix_in_if.sv
// Pixel request channel: valid/ready with the three color channels.
interface pix_in_if;
	logic                     valid;
	logic                     ready;
	logic [rgbled_pkg::ChanW-1:0] red_in;
	logic [rgbled_pkg::ChanW-1:0] green_in;
	logic [rgbled_pkg::ChanW-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

### design/led_out_if.sv
// LED word request channel: valid/ready with header and scaled color bytes.
interface led_out_if;
	logic                     valid;
	logic                     ready;
	logic [rgbled_pkg::ChanW-1:0] header_byte;
	logic [rgbled_pkg::ChanW-1:0] red_out;
	logic [rgbled_pkg::ChanW-1:0] green_out;
	logic [rgbled_pkg::ChanW-1:0] blue_out;

	modport source (output valid, header_byte, red_out, green_out, blue_out, input ready);
	modport sink   (input valid, header_byte, red_out, green_out, blue_out, output ready);
endinterface

### design/rgb_to_global_brightness_led_word.sv
// Top level: four-stage pipeline from RGB pixel to LED word with global brightness.
//
//   channel  dir  handshake     payload
//   pix      in   valid/ready   red_in, green_in, blue_in
//   led      out  valid/ready   header_byte, red_out, green_out, blue_out
//
// One pixel is taken every cycle while led.ready is high.
// The stages: brightness, numerator and reciprocal lookup, reciprocal multiply,
// remainder check and correction into the output register.
// The whole pipeline holds while a word waits at the output, so pix.ready follows led.ready
// whenever the last stage is full. Reset clears only the stage valid bits.
module rgb_to_global_brightness_led_word (
	input  logic clk,
	input  logic arst_n,
	pix_in_if.sink   pix,
	led_out_if.source led
);
	import rgbled_pkg::*;

	logic   en;
	logic   v_s1, v_s2, v_s3, v_s4;
	pix_t   pix_in, pix_s1;
	level_t level_s1;
	chan_t  hdr_s2, hdr_s3, hdr_s4;

	assign en        = !v_s4 || led.ready;
	assign pix.ready = en;

	assign pix_in.red   = pix.red_in;
	assign pix_in.green = pix.green_in;
	assign pix_in.blue  = pix.blue_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s2 <= HeaderMark | {3'd0, level_s1};
			hdr_s3 <= hdr_s2;
			hdr_s4 <= hdr_s3;
		end
	end

	rgbled_level u_level (
		.clk      (clk),
		.en       (en),
		.pix      (pix_in),
		.pix_s1   (pix_s1),
		.level_s1 (level_s1)
	);

	rgbled_scale u_red (
		.clk      (clk),
		.en       (en),
		.chan_s1  (pix_s1.red),
		.level_s1 (level_s1),
		.chan_s4  (led.red_out)
	);

	rgbled_scale u_green (
		.clk      (clk),
		.en       (en),
		.chan_s1  (pix_s1.green),
		.level_s1 (level_s1),
		.chan_s4  (led.green_out)
	);

	rgbled_scale u_blue (
		.clk      (clk),
		.en       (en),
		.chan_s1  (pix_s1.blue),
		.level_s1 (level_s1),
		.chan_s4  (led.blue_out)
	);

	assign led.valid       = v_s4;
	assign led.header_byte = hdr_s4;

	a_header_range: assert property (@(posedge clk) disable iff (!arst_n)
		led.valid |-> (led.header_byte[7:5] == 3'b111 && led.header_byte[4:0] != 5'd0))
		else $error("header byte out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> v_s1)
		else $error("accepted pixel not in stage 1");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		led.valid && !led.ready |-> !pix.ready)
		else $error("input taken while output stalled");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 |=> led.valid)
		else $error("stage 3 item lost on advance");

endmodule

### design/rgbled_level.sv
// Stage 1: peak channel and 5-bit global brightness.
module rgbled_level (
	input  logic              clk,
	input  logic              en,
	input  rgbled_pkg::pix_t  pix,
	output rgbled_pkg::pix_t  pix_s1,
	output rgbled_pkg::level_t level_s1
);
	import rgbled_pkg::*;

	chan_t       peak;
	logic [8:0]  peak_p1;
	logic [12:0] scaled;
	level_t      level;

	always_comb begin
		peak = pix.red;
		if (pix.green > peak) begin
			peak = pix.green;
		end
		if (pix.blue > peak) begin
			peak = pix.blue;
		end
		peak_p1 = {1'b0, peak} + 9'd1;
		// (peak + 1) * 31 - 1 as shift and subtract
		scaled  = ({peak_p1, 4'd0} << 1) - {4'd0, peak_p1} - 13'd1;
		level   = level_t'(scaled[12:8]) + 5'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= pix;
			level_s1 <= level;
		end
	end

endmodule

### design/rgbled_scale.sv
// Stages 2 to 4: rounded channel * 31 / level by reciprocal multiply and one correction.
module rgbled_scale (
	input  logic               clk,
	input  logic               en,
	input  rgbled_pkg::chan_t  chan_s1,
	input  rgbled_pkg::level_t level_s1,
	output rgbled_pkg::chan_t  chan_s4
);
	import rgbled_pkg::*;

	num_t   num_s2, num_s3;
	recip_t recip_s2;
	level_t level_s2, level_s3;
	num_t   quot_s3;

	num_t             num;
	logic [ProdW-1:0] prod;
	logic [RemW-1:0]  back;
	logic [RemW-1:0]  rem;
	num_t             quot;

	always_comb begin
		num  = ({5'd0, chan_s1} << 5) - {5'd0, chan_s1} + {9'd0, level_s1[LevelW-1:1]};
		prod = {{RecipW{1'b0}}, num_s2} * {{NumW{1'b0}}, recip_s2};
		back = {{LevelW{1'b0}}, quot_s3} * {{NumW{1'b0}}, level_s3};
		rem  = {{LevelW{1'b0}}, num_s3} - back;
		// estimate is low by at most one
		quot = quot_s3;
		if (rem >= {{NumW{1'b0}}, level_s3}) begin
			quot = quot_s3 + 13'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= num;
			recip_s2 <= recip(level_s1);
			level_s2 <= level_s1;
			quot_s3  <= prod[RecipSh +: NumW];
			num_s3   <= num_s2;
			level_s3 <= level_s2;
			chan_s4  <= quot[ChanW-1:0];
		end
	end

endmodule
